// ----- hw/rtl/msaq_pkg.sv -----
package msaq_pkg;

  localparam int unsigned CNT_W = 8;
  localparam int unsigned TEMP_W = 12;
  localparam int unsigned ALC_W = 16;
  localparam int unsigned FLAGS_W = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_HIGH_LEVEL   = 3'd0,
    REG_TEMP_DANGER_LEVEL = 3'd1,
    REG_ALCOHOL_LEVEL_LIM = 3'd2,
    REG_FLAME_COUNT_LIM   = 3'd3,
    REG_HIGH_TEMP_CNT_LIM = 3'd4,
    REG_DANGER_CNT_LIM    = 3'd5,
    REG_ALCOHOL_CNT_LIM   = 3'd6,
    REG_LEAK_COUNT_LIM    = 3'd7
  } cfg_reg_t;

  localparam int unsigned FLAG_FLAME = 0;
  localparam int unsigned FLAG_HIGH_TEMP = 1;
  localparam int unsigned FLAG_DANGER_TEMP = 2;
  localparam int unsigned FLAG_ALCOHOL = 3;
  localparam int unsigned FLAG_LOW_FLUID = 4;
  localparam int unsigned FLAG_LEAK = 5;

  localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 12'sd400;
  localparam logic signed [TEMP_W-1:0] TEMP_DANGER_RST = 12'sd700;
  localparam logic [ALC_W-1:0] ALC_LEVEL_RST = 16'h3000;
  localparam logic [CNT_W-1:0] FLAME_LIM_RST = 8'd10;
  localparam logic [CNT_W-1:0] HIGH_LIM_RST = 8'd10;
  localparam logic [CNT_W-1:0] DANGER_LIM_RST = 8'd20;
  localparam logic [CNT_W-1:0] ALC_LIM_RST = 8'd20;
  localparam logic [CNT_W-1:0] LEAK_LIM_RST = 8'd10;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

endpackage

// ----- hw/rtl/multi_sensor_alarm_qualifier.sv -----
// An accepted item is held in the input register and then in the result register until it is taken.
// Throughput: one item per cycle while results are taken; the persistence counters update as an item
// moves from the input register into the result register.
// One further item is held in the input register while a result waits to be taken.
// Reset (rst_n low, synchronous) clears all counters, turns the fan off, empties both
// registers and loads the threshold registers with their default values.
module multi_sensor_alarm_qualifier
  import msaq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_flame_pin,
  input  logic                     in_leak_pin,
  input  logic                     in_fluid_ok_pin,
  input  logic signed [TEMP_W-1:0] in_temperature,
  input  logic [ALC_W-1:0]         in_alcohol_level,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FLAGS_W-1:0]       out_unsafe_flags,
  output logic                     out_critical,
  output logic                     out_fan_on,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  // Configuration registers.
  logic signed [TEMP_W-1:0] temp_high_r;
  logic signed [TEMP_W-1:0] temp_danger_r;
  logic [ALC_W-1:0]         alc_level_r;
  logic [CNT_W-1:0]         flame_lim_r;
  logic [CNT_W-1:0]         high_lim_r;
  logic [CNT_W-1:0]         danger_lim_r;
  logic [CNT_W-1:0]         alc_lim_r;
  logic [CNT_W-1:0]         leak_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_high_r   <= TEMP_HIGH_RST;
      temp_danger_r <= TEMP_DANGER_RST;
      alc_level_r   <= ALC_LEVEL_RST;
      flame_lim_r   <= FLAME_LIM_RST;
      high_lim_r    <= HIGH_LIM_RST;
      danger_lim_r  <= DANGER_LIM_RST;
      alc_lim_r     <= ALC_LIM_RST;
      leak_lim_r    <= LEAK_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEMP_HIGH_LEVEL:   temp_high_r   <= $signed(cfg_wdata[TEMP_W-1:0]);
        REG_TEMP_DANGER_LEVEL: temp_danger_r <= $signed(cfg_wdata[TEMP_W-1:0]);
        REG_ALCOHOL_LEVEL_LIM: alc_level_r   <= cfg_wdata[ALC_W-1:0];
        REG_FLAME_COUNT_LIM:   flame_lim_r   <= cfg_wdata[CNT_W-1:0];
        REG_HIGH_TEMP_CNT_LIM: high_lim_r    <= cfg_wdata[CNT_W-1:0];
        REG_DANGER_CNT_LIM:    danger_lim_r  <= cfg_wdata[CNT_W-1:0];
        REG_ALCOHOL_CNT_LIM:   alc_lim_r     <= cfg_wdata[CNT_W-1:0];
        REG_LEAK_COUNT_LIM:    leak_lim_r    <= cfg_wdata[CNT_W-1:0];
        default:               leak_lim_r    <= cfg_wdata[CNT_W-1:0];
      endcase
    end
  end

  // Input register.
  logic                     s1_valid_r;
  logic                     s1_flame_r;
  logic                     s1_leak_r;
  logic                     s1_fluid_ok_r;
  logic signed [TEMP_W-1:0] s1_temp_r;
  logic [ALC_W-1:0]         s1_alc_r;

  logic s2_load;
  logic in_take;

  assign s2_load  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s2_load;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_flame_r    <= in_flame_pin;
      s1_leak_r     <= in_leak_pin;
      s1_fluid_ok_r <= in_fluid_ok_pin;
      s1_temp_r     <= in_temperature;
      s1_alc_r      <= in_alcohol_level;
    end
  end

  // Persistence state.
  logic [CNT_W-1:0] flame_cnt_r, flame_cnt_nxt;
  logic [CNT_W-1:0] high_cnt_r, high_cnt_nxt;
  logic [CNT_W-1:0] danger_cnt_r, danger_cnt_nxt;
  logic [CNT_W-1:0] alc_cnt_r, alc_cnt_nxt;
  logic [CNT_W-1:0] leak_cnt_r, leak_cnt_nxt;
  logic             fan_r, fan_nxt;
  logic [FLAGS_W-1:0] flags_nxt;
  logic             temp_normal;
  logic             temp_high;

  always_comb begin
    flags_nxt      = '0;
    high_cnt_nxt   = high_cnt_r;
    danger_cnt_nxt = danger_cnt_r;
    fan_nxt        = fan_r;

    flame_cnt_nxt = s1_flame_r ? '0 : sat_inc(flame_cnt_r);
    flags_nxt[FLAG_FLAME] = (flame_cnt_nxt >= flame_lim_r);

    temp_normal = (s1_temp_r < temp_high_r);
    temp_high   = (s1_temp_r < temp_danger_r);
    if (temp_normal) begin
      fan_nxt        = 1'b0;
      high_cnt_nxt   = '0;
      danger_cnt_nxt = '0;
    end else if (temp_high) begin
      high_cnt_nxt = sat_inc(high_cnt_r);
      if (high_cnt_nxt > high_lim_r) begin
        fan_nxt = 1'b1;
        flags_nxt[FLAG_HIGH_TEMP] = 1'b1;
      end
    end else begin
      danger_cnt_nxt = sat_inc(danger_cnt_r);
      if (danger_cnt_nxt > danger_lim_r) begin
        fan_nxt = 1'b1;
        flags_nxt[FLAG_DANGER_TEMP] = 1'b1;
      end
    end

    if (s1_alc_r > alc_level_r) begin
      alc_cnt_nxt = sat_inc(alc_cnt_r);
      flags_nxt[FLAG_ALCOHOL] = (alc_cnt_nxt > alc_lim_r);
    end else begin
      alc_cnt_nxt = '0;
    end

    flags_nxt[FLAG_LOW_FLUID] = !s1_fluid_ok_r;

    // A zero leak limit still needs a leak on this tick to raise the flag.
    if (!s1_leak_r) begin
      leak_cnt_nxt = sat_inc(leak_cnt_r);
      flags_nxt[FLAG_LEAK] = (leak_cnt_nxt >= leak_lim_r);
    end else begin
      leak_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flame_cnt_r  <= '0;
      high_cnt_r   <= '0;
      danger_cnt_r <= '0;
      alc_cnt_r    <= '0;
      leak_cnt_r   <= '0;
      fan_r        <= 1'b0;
    end else if (s2_load) begin
      flame_cnt_r  <= flame_cnt_nxt;
      high_cnt_r   <= high_cnt_nxt;
      danger_cnt_r <= danger_cnt_nxt;
      alc_cnt_r    <= alc_cnt_nxt;
      leak_cnt_r   <= leak_cnt_nxt;
      fan_r        <= fan_nxt;
    end
  end

  // Result register.
  logic               out_valid_r;
  logic [FLAGS_W-1:0] out_flags_r;
  logic               out_unsafe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_flags_r  <= flags_nxt;
      out_unsafe_r <= flags_nxt[FLAG_FLAME] | flags_nxt[FLAG_DANGER_TEMP] |
                      flags_nxt[FLAG_ALCOHOL] | flags_nxt[FLAG_LEAK];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_unsafe_flags = out_flags_r;
  assign out_critical     = out_unsafe_r;
  assign out_fan_on       = fan_r;

`ifndef SYNTHESIS
  a_unsafe_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_critical == (out_unsafe_flags[FLAG_FLAME] |
      out_unsafe_flags[FLAG_DANGER_TEMP] | out_unsafe_flags[FLAG_ALCOHOL] |
      out_unsafe_flags[FLAG_LEAK])))
    else $error("critical output disagrees with the critical flags");

  a_temp_flag_fan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_unsafe_flags[FLAG_HIGH_TEMP] || out_unsafe_flags[FLAG_DANGER_TEMP]))
      |-> out_fan_on)
    else $error("qualified temperature flag without the fan running");

  a_state_held_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_load |=> ($stable(flame_cnt_r) && $stable(leak_cnt_r) && $stable(fan_r)))
    else $error("persistence state changed without an item moving");

  a_item_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_load) |=> s1_valid_r)
    else $error("buffered item dropped while the result register was stalled");
`endif

endmodule
